/* rtl/hrd_pkg.sv */
// Shared types and constants for the row distance block.
package hrd_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int SUM_WIDTH   = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int ROOT_STEPS  = 32;

   typedef enum logic [1:0] {
      TERM_ZERO,
      TERM_ONE,
      TERM_NUMERIC
   } term_kind_type;

   typedef enum logic [1:0] {
      ROOT_IDLE,
      ROOT_RUN,
      ROOT_DONE
   } root_state_type;

   typedef struct packed {
      logic [SUM_WIDTH-1:0] sum;
      logic                 saturated;
   } row_entry_type;

endpackage

/* rtl/hrd_front.sv */
// Front end: term pipeline and saturating row accumulator.
module hrd_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic signed [31:0]    query_value,
   input  logic                  query_missing,
   input  logic signed [31:0]    row_value,
   input  logic                  row_missing,
   input  logic                  is_numeric,
   input  logic [31:0]           inverse_range,
   input  logic                  last_of_row,
   output logic                  q_push,
   output hrd_pkg::row_entry_type q_entry,
   input  logic                  q_full
);
   import hrd_pkg::*;

   localparam logic [SUM_WIDTH-1:0] ONE_FX = SUM_WIDTH'(1) << FRAC_BITS;

   logic                   a_valid_ff, b_valid_ff, c_valid_ff;
   logic                   a_last_ff, b_last_ff, c_last_ff;
   term_kind_type          a_kind_ff, b_kind_ff, c_kind_ff;
   logic [32:0]            a_mag_ff;
   logic [31:0]            a_inv_ff;
   logic [64:0]            b_prod_ff;
   logic [63:0]            c_sq_ff;
   logic                   c_scaled_sat_ff;
   logic [SUM_WIDTH-1:0]   row_sum_ff, row_sum_in;
   logic                   row_sat_ff, row_sat_in;

   logic                   stall, advance, accept;
   logic [32:0]            diff;
   logic [32:0]            mag;
   term_kind_type          kind;
   logic [64:0]            prod_in;
   logic [64:0]            scaled_wide;
   logic                   scaled_sat;
   logic [31:0]            scaled;
   logic [63:0]            sq_in;
   logic [63:0]            sq_shift;
   logic                   term_sat;
   logic [SUM_WIDTH-1:0]   num_term;
   logic [SUM_WIDTH-1:0]   term;
   logic [SUM_WIDTH:0]     sum_wide;
   logic [SUM_WIDTH-1:0]   sum_new;
   logic                   sat_new;

   assign stall   = c_valid_ff & c_last_ff & q_full;
   assign advance = ~stall;
   assign full    = stall;
   assign accept  = push & ~full;

   always_comb begin
      diff = {query_value[31], query_value} - {row_value[31], row_value};
      mag  = diff[32] ? (~diff + 33'd1) : diff;
      if (query_missing || row_missing) begin
         kind = TERM_ONE;
      end else if (is_numeric) begin
         kind = TERM_NUMERIC;
      end else if (query_value != row_value) begin
         kind = TERM_ONE;
      end else begin
         kind = TERM_ZERO;
      end
   end

   assign prod_in = 65'(a_mag_ff) * 65'(a_inv_ff);

   always_comb begin
      scaled_wide = b_prod_ff >> FRAC_BITS;
      scaled_sat  = |scaled_wide[64:32];
      scaled      = scaled_sat ? 32'hFFFF_FFFF : scaled_wide[31:0];
      sq_in       = 64'(scaled) * 64'(scaled);
   end

   always_comb begin
      sq_shift = c_sq_ff >> FRAC_BITS;
      term_sat = |sq_shift[63:SUM_WIDTH];
      num_term = term_sat ? '1 : sq_shift[SUM_WIDTH-1:0];
      case (c_kind_ff)
         TERM_ONE:     term = ONE_FX;
         TERM_NUMERIC: term = num_term;
         default:      term = '0;
      endcase
      sum_wide = {1'b0, row_sum_ff} + {1'b0, term};
      sum_new  = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
      sat_new  = row_sat_ff | sum_wide[SUM_WIDTH]
               | ((c_kind_ff == TERM_NUMERIC) & (c_scaled_sat_ff | term_sat));

      q_push          = c_valid_ff & c_last_ff & ~q_full;
      q_entry.sum       = sum_new;
      q_entry.saturated = sat_new;

      row_sum_in = row_sum_ff;
      row_sat_in = row_sat_ff;
      if (advance && c_valid_ff) begin
         if (c_last_ff) begin
            row_sum_in = '0;
            row_sat_in = 1'b0;
         end else begin
            row_sum_in = sum_new;
            row_sat_in = sat_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         row_sum_ff <= '0;
         row_sat_ff <= 1'b0;
      end else begin
         if (advance) begin
            a_valid_ff <= accept;
            b_valid_ff <= a_valid_ff;
            c_valid_ff <= b_valid_ff;
         end
         row_sum_ff <= row_sum_in;
         row_sat_ff <= row_sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_last_ff       <= last_of_row;
         a_kind_ff       <= kind;
         a_mag_ff        <= mag;
         a_inv_ff        <= inverse_range;
         b_last_ff       <= a_last_ff;
         b_kind_ff       <= a_kind_ff;
         b_prod_ff       <= prod_in;
         c_last_ff       <= b_last_ff;
         c_kind_ff       <= b_kind_ff;
         c_sq_ff         <= sq_in;
         c_scaled_sat_ff <= scaled_sat;
      end
   end

endmodule

/* rtl/hrd_queue.sv */
// Short queue of finished row sums between the front end and the root unit.
module hrd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hrd_pkg::row_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output hrd_pkg::row_entry_type pop_entry,
   output logic                   empty
);
   import hrd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   row_entry_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("Row queue count exceeds its depth.");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("Front end pushed a row sum into a full queue.");

endmodule

/* rtl/hrd_root.sv */
// Back end: bit-serial square root of each row sum and the result register.
module hrd_root #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hrd_pkg::row_entry_type q_entry,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   empty,
   input  logic                   pop,
   output logic [31:0]            distance,
   output logic                   saturated
);
   import hrd_pkg::*;

   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int ROOT_SHIFT = 64 - FRAC_BITS;

   root_state_type    state_ff, state_in;
   logic [63:0]       rad_ff, rad_in;
   logic [33:0]       rem_ff, rem_in;
   logic [31:0]       root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              ovf_ff, ovf_in;
   logic              row_sat_ff, row_sat_in;
   logic              out_valid_ff;
   logic [31:0]       distance_ff;
   logic              sat_out_ff;

   logic [63:0]       sum_wide;
   logic [35:0]       rem_shift;
   logic [35:0]       trial;
   logic [35:0]       rem_diff;
   logic              out_load;
   logic              out_pop;

   assign out_pop   = pop & out_valid_ff;
   assign empty     = ~out_valid_ff;
   assign distance  = distance_ff;
   assign saturated = sat_out_ff;

   always_comb begin
      sum_wide  = 64'(q_entry.sum);
      rem_shift = {rem_ff, rad_ff[63:62]};
      trial     = {2'b00, root_ff, 2'b01};
      rem_diff  = rem_shift - trial;

      state_in   = state_ff;
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      step_in    = step_ff;
      ovf_in     = ovf_ff;
      row_sat_in = row_sat_ff;
      q_pop      = 1'b0;
      out_load   = 1'b0;

      unique case (state_ff)
         ROOT_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               rad_in     = sum_wide << FRAC_BITS;
               rem_in     = '0;
               root_in    = '0;
               step_in    = STEP_W'(ROOT_STEPS - 1);
               ovf_in     = |(sum_wide >> ROOT_SHIFT);
               row_sat_in = q_entry.saturated;
               state_in   = ROOT_RUN;
            end
         end
         ROOT_RUN: begin
            rad_in = {rad_ff[61:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_in  = rem_diff[33:0];
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_shift[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = ROOT_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ROOT_DONE: begin
            if (!out_valid_ff || pop) begin
               out_load = 1'b1;
               state_in = ROOT_IDLE;
            end
         end
         default: begin
            state_in = ROOT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ROOT_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      step_ff    <= step_in;
      ovf_ff     <= ovf_in;
      row_sat_ff <= row_sat_in;
      if (out_load) begin
         distance_ff <= ovf_ff ? 32'hFFFF_FFFF : root_ff;
         sat_out_ff  <= row_sat_ff | ovf_ff;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |-> !out_load)
      else $error("Result register overwritten before its transaction completed.");

   a_overflow_result: assert property (@(posedge clock) disable iff (reset)
      (out_load && ovf_ff) |=> (distance_ff == 32'hFFFF_FFFF) && sat_out_ff)
      else $error("Overflowing row sum did not give a saturated distance.");

endmodule

/* rtl/heom_row_distance.sv */
// Top level of the streaming heterogeneous row distance block.
//
// One variable pair is taken per transaction and, with no stall from the back end, one per
// cycle; each pair passes a three-stage term pipeline into a saturating row accumulator.
// At the pair flagged last of row the row sum enters a two-entry queue, and a bit-serial
// square root unit takes it and runs its ROOT_STEPS root steps on it before the result
// appears. The root unit takes a new row sum only once it is through with the last, so
// short rows are throttled once the queue has filled, and rows longer than a root run
// stream at one pair per cycle while results are popped. A row's result is loaded into
// the result register after its last pair has passed the term stages, queue and root run.
module heom_row_distance #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [31:0] req_query_value,
   input  logic               req_query_missing,
   input  logic signed [31:0] req_row_value,
   input  logic               req_row_missing,
   input  logic               req_is_numeric,
   input  logic [31:0]        req_inverse_range,
   input  logic               req_last_of_row,
   output logic               empty,
   input  logic               pop,
   output logic [31:0]        rsp_distance,
   output logic               rsp_saturated
);
   import hrd_pkg::*;

   row_entry_type push_entry;
   row_entry_type pop_entry;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;

   hrd_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .query_value   (req_query_value),
      .query_missing (req_query_missing),
      .row_value     (req_row_value),
      .row_missing   (req_row_missing),
      .is_numeric    (req_is_numeric),
      .inverse_range (req_inverse_range),
      .last_of_row   (req_last_of_row),
      .q_push        (q_push),
      .q_entry       (push_entry),
      .q_full        (q_full)
   );

   hrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   hrd_root #(
      .FRAC_BITS(FRAC_BITS)
   ) u_root (
      .clock     (clock),
      .reset     (reset),
      .q_entry   (pop_entry),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .empty     (empty),
      .pop       (pop),
      .distance  (rsp_distance),
      .saturated (rsp_saturated)
   );

endmodule
